>>> hdl/nearest_segment_point_to_anchor_top_assert.svh
// Assertion macros shared by the nearest segment point pipeline.
// Needs signals named clock and reset in the module that includes it.
`ifndef NEAREST_SEGMENT_POINT_TO_ANCHOR_TOP_ASSERT_SVH
`define NEAREST_SEGMENT_POINT_TO_ANCHOR_TOP_ASSERT_SVH

// Same-cycle implication
`define NSPA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define NSPA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/nspa_pkg.sv
// Package for the nearest segment point pipeline: widths, payload types, codes.
// No dependencies.
`timescale 1ns / 1ps
package nspa_pkg;

   localparam int COORD_W = 16;
   localparam int CFG_W   = 15;
   localparam int SEL_W   = 3;
   localparam int DIFF_W  = 17;   // f - s
   localparam int UDIF_W  = 18;   // anchor - point
   localparam int PROD_W  = 35;
   localparam int CROSS_W = 36;
   localparam int DOT_W   = 37;
   localparam int MAG_W   = 36;
   localparam int DD_W    = 34;
   localparam int HALF_A  = 18;
   localparam int HALF_D  = 17;
   localparam int PA_W    = 2 * HALF_A;
   localparam int PD_W    = 2 * HALF_D;
   localparam int SQA_W   = 2 * MAG_W;
   localparam int SQD_W   = 68;

   localparam logic [SEL_W-1:0] WINCH_A = 3'd0;
   localparam logic [SEL_W-1:0] WINCH_B = 3'd1;
   localparam logic [SEL_W-1:0] WINCH_C = 3'd2;

   typedef enum logic [2:0] {
      REG_A_X_OFF = 3'd0,
      REG_B_X_OFF = 3'd1,
      REG_B_Y     = 3'd2,
      REG_C_X     = 3'd3,
      REG_C_Y     = 3'd4,
      REG_D_X     = 3'd5
   } csr_idx_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [CFG_W-1:0] a_x_off;
      logic [CFG_W-1:0] b_x_off;
      logic [CFG_W-1:0] b_y;
      logic [CFG_W-1:0] c_x;
      logic [CFG_W-1:0] c_y;
      logic [CFG_W-1:0] d_x;
   } anchor_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type sz;
      coord_type fx;
      coord_type fy;
      coord_type fz;
   } seg_type;

   // Decisions made ahead of the interpolation
   typedef struct packed {
      seg_type seg;
      logic    near_start;
      logic    collinear;
      logic    outside;
      logic    pf_gt;
      logic    pf_lt;
      logic    zero_horiz;
   } side_type;

   typedef struct packed {
      logic [MAG_W-1:0] apf;
      logic [DD_W-1:0]  dd;
   } divop_type;

   typedef struct packed {
      coord_type near_x;
      coord_type near_y;
      coord_type near_z;
   } res_type;

endpackage

>>> hdl/nspa_req_if.sv
// Request channel interface: segment end points and winch number.
// Depends on nspa_pkg.
`timescale 1ns / 1ps
interface nspa_req_if;
   import nspa_pkg::*;
   logic             valid;
   logic             ready;
   coord_type        seg_start_x;
   coord_type        seg_start_y;
   coord_type        seg_start_z;
   coord_type        seg_end_x;
   coord_type        seg_end_y;
   coord_type        seg_end_z;
   logic [SEL_W-1:0] winch_sel;

   modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
                   seg_end_x, seg_end_y, seg_end_z, winch_sel, input ready);
   modport sink   (input valid, seg_start_x, seg_start_y, seg_start_z,
                   seg_end_x, seg_end_y, seg_end_z, winch_sel, output ready);
endinterface

>>> hdl/nspa_rsp_if.sv
// Response channel interface: nearest point coordinates.
// Depends on nspa_pkg.
`timescale 1ns / 1ps
interface nspa_rsp_if;
   import nspa_pkg::*;
   logic      valid;
   logic      ready;
   coord_type near_x;
   coord_type near_y;
   coord_type near_z;

   modport source (output valid, near_x, near_y, near_z, input ready);
   modport sink   (input valid, near_x, near_y, near_z, output ready);
endinterface

>>> hdl/nspa_front.sv
// Geometry front end: differences, dot and cross products, magnitudes and
// the outside-segment test, seven register stages. Depends on nspa_pkg.
`timescale 1ns / 1ps
module nspa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  nspa_pkg::anchor_type          anchors,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  nspa_pkg::seg_type             in_seg,
   input  logic [nspa_pkg::SEL_W-1:0]    in_sel,
   output logic                          out_valid,
   input  logic                          out_ready,
   output nspa_pkg::side_type            out_side,
   output nspa_pkg::divop_type           out_op
);
   import nspa_pkg::*;

   localparam int NST = 7;

   logic [NST-1:0] vld_ff, vld_in;
   logic           en;
   side_type       sd_ff [NST];
   side_type       sd_in [NST];

   // stage 0: differences
   logic signed [UDIF_W-1:0] ax, ay;
   logic signed [DIFF_W-1:0] e_ff [3], e_in [3];
   logic signed [UDIF_W-1:0] u_ff [3], u_in [3];
   logic signed [UDIF_W-1:0] v_ff [3], v_in [3];
   // stage 1: products
   logic signed [PROD_W-1:0] pc_ff [6], pc_in [6];
   logic signed [PROD_W-1:0] pee_ff [3], pee_in [3];
   logic signed [PROD_W-1:0] pu_ff [3], pu_in [3];
   logic signed [PROD_W-1:0] pv_ff [3], pv_in [3];
   // stage 2: sums
   logic signed [CROSS_W-1:0] c_ff [3], c_in [3];
   logic [DD_W-1:0]           dd2_ff, dd2_in, d22_ff, d22_in;
   logic signed [DOT_W-1:0]   ps_ff, ps_in, pf_ff, pf_in;
   // stage 3: magnitudes
   logic [MAG_W-1:0] apf3_ff, apf3_in, aps3_ff, aps3_in;
   logic [DD_W-1:0]  dd3_ff, d23_ff;
   // stage 4: partial products of the squares
   logic [PA_W-1:0]  pa_ff [3], pa_in [3], pb_ff [3], pb_in [3];
   logic [PD_W-1:0]  pd_ff [4], pd_in [4];
   logic [MAG_W-1:0] apf4_ff;
   logic [DD_W-1:0]  dd4_ff;
   // stage 5: squares
   logic [SQA_W-1:0] sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [SQD_W-1:0] sqd_ff, sqd_in;
   logic [MAG_W-1:0] apf5_ff;
   logic [DD_W-1:0]  dd5_ff;
   // stage 6: outside test
   divop_type        op6_ff;

   // whole front advances together unless its last stage is blocked
   always_comb begin
      en       = !vld_ff[NST-1] || out_ready;
      in_ready = en;
      vld_in   = en ? {vld_ff[NST-2:0], in_valid} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // anchor of the chosen winch
   always_comb begin
      case (in_sel)
         WINCH_A: begin
            ax = UDIF_W'(0) - UDIF_W'(anchors.a_x_off);
            ay = '0;
         end
         WINCH_B: begin
            ax = UDIF_W'(0) - UDIF_W'(anchors.b_x_off);
            ay = UDIF_W'(anchors.b_y);
         end
         WINCH_C: begin
            ax = UDIF_W'(anchors.c_x);
            ay = UDIF_W'(anchors.c_y);
         end
         default: begin
            ax = UDIF_W'(anchors.d_x);
            ay = '0;
         end
      endcase
   end

   // stage 0 inputs
   always_comb begin
      e_in[0] = DIFF_W'(in_seg.fx) - DIFF_W'(in_seg.sx);
      e_in[1] = DIFF_W'(in_seg.fy) - DIFF_W'(in_seg.sy);
      e_in[2] = DIFF_W'(in_seg.fz) - DIFF_W'(in_seg.sz);
      u_in[0] = ax - UDIF_W'(in_seg.sx);
      u_in[1] = ay - UDIF_W'(in_seg.sy);
      u_in[2] = UDIF_W'(0) - UDIF_W'(in_seg.sz);
      v_in[0] = ax - UDIF_W'(in_seg.fx);
      v_in[1] = ay - UDIF_W'(in_seg.fy);
      v_in[2] = UDIF_W'(0) - UDIF_W'(in_seg.fz);
      sd_in[0]            = '0;
      sd_in[0].seg        = in_seg;
      // collinear choice: low winches take the end with the smaller x
      sd_in[0].near_start = (in_seg.sx <= in_seg.fx) ? (in_sel < WINCH_C)
                                                     : !(in_sel < WINCH_C);
   end

   // stage 1 inputs: products
   always_comb begin
      pc_in[0] = PROD_W'(e_ff[1]) * PROD_W'(u_ff[2]);
      pc_in[1] = PROD_W'(e_ff[2]) * PROD_W'(u_ff[1]);
      pc_in[2] = PROD_W'(e_ff[2]) * PROD_W'(u_ff[0]);
      pc_in[3] = PROD_W'(e_ff[0]) * PROD_W'(u_ff[2]);
      pc_in[4] = PROD_W'(e_ff[0]) * PROD_W'(u_ff[1]);
      pc_in[5] = PROD_W'(e_ff[1]) * PROD_W'(u_ff[0]);
      for (int i = 0; i < 3; i++) begin
         pee_in[i] = PROD_W'(e_ff[i]) * PROD_W'(e_ff[i]);
         pu_in[i]  = PROD_W'(u_ff[i]) * PROD_W'(e_ff[i]);
         pv_in[i]  = PROD_W'(v_ff[i]) * PROD_W'(e_ff[i]);
      end
      sd_in[1] = sd_ff[0];
   end

   // stage 2 inputs: cross product, lengths, dot products
   always_comb begin
      c_in[0] = CROSS_W'(pc_ff[0]) - CROSS_W'(pc_ff[1]);
      c_in[1] = CROSS_W'(pc_ff[2]) - CROSS_W'(pc_ff[3]);
      c_in[2] = CROSS_W'(pc_ff[4]) - CROSS_W'(pc_ff[5]);
      dd2_in  = DD_W'(DOT_W'(pee_ff[0]) + DOT_W'(pee_ff[1]) + DOT_W'(pee_ff[2]));
      d22_in  = DD_W'(DOT_W'(pee_ff[0]) + DOT_W'(pee_ff[1]));
      ps_in   = DOT_W'(pu_ff[0]) + DOT_W'(pu_ff[1]) + DOT_W'(pu_ff[2]);
      pf_in   = DOT_W'(pv_ff[0]) + DOT_W'(pv_ff[1]) + DOT_W'(pv_ff[2]);
      sd_in[2] = sd_ff[1];
   end

   // stage 3 inputs: magnitudes and flags
   always_comb begin
      apf3_in = pf_ff[DOT_W-1] ? MAG_W'(-pf_ff) : MAG_W'(pf_ff);
      aps3_in = ps_ff[DOT_W-1] ? MAG_W'(-ps_ff) : MAG_W'(ps_ff);
      sd_in[3]            = sd_ff[2];
      sd_in[3].collinear  = (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
      sd_in[3].zero_horiz = (d22_ff == '0);
      sd_in[3].pf_gt      = apf3_in > aps3_in;
      sd_in[3].pf_lt      = apf3_in < aps3_in;
   end

   // stage 4 inputs: split squares into narrow partial products
   always_comb begin
      pa_in[0] = PA_W'(apf3_ff[MAG_W-1:HALF_A]) * PA_W'(apf3_ff[MAG_W-1:HALF_A]);
      pa_in[1] = PA_W'(apf3_ff[MAG_W-1:HALF_A]) * PA_W'(apf3_ff[HALF_A-1:0]);
      pa_in[2] = PA_W'(apf3_ff[HALF_A-1:0]) * PA_W'(apf3_ff[HALF_A-1:0]);
      pb_in[0] = PA_W'(aps3_ff[MAG_W-1:HALF_A]) * PA_W'(aps3_ff[MAG_W-1:HALF_A]);
      pb_in[1] = PA_W'(aps3_ff[MAG_W-1:HALF_A]) * PA_W'(aps3_ff[HALF_A-1:0]);
      pb_in[2] = PA_W'(aps3_ff[HALF_A-1:0]) * PA_W'(aps3_ff[HALF_A-1:0]);
      pd_in[0] = PD_W'(dd3_ff[DD_W-1:HALF_D]) * PD_W'(d23_ff[DD_W-1:HALF_D]);
      pd_in[1] = PD_W'(dd3_ff[DD_W-1:HALF_D]) * PD_W'(d23_ff[HALF_D-1:0]);
      pd_in[2] = PD_W'(dd3_ff[HALF_D-1:0]) * PD_W'(d23_ff[DD_W-1:HALF_D]);
      pd_in[3] = PD_W'(dd3_ff[HALF_D-1:0]) * PD_W'(d23_ff[HALF_D-1:0]);
      sd_in[4] = sd_ff[3];
   end

   // stage 5 inputs: recombine
   always_comb begin
      sqa_in = (SQA_W'(pa_ff[0]) << (2 * HALF_A)) + (SQA_W'(pa_ff[1]) << (HALF_A + 1))
               + SQA_W'(pa_ff[2]);
      sqb_in = (SQA_W'(pb_ff[0]) << (2 * HALF_A)) + (SQA_W'(pb_ff[1]) << (HALF_A + 1))
               + SQA_W'(pb_ff[2]);
      sqd_in = (SQD_W'(pd_ff[0]) << (2 * HALF_D))
               + ((SQD_W'(pd_ff[1]) + SQD_W'(pd_ff[2])) << HALF_D) + SQD_W'(pd_ff[3]);
      sd_in[5] = sd_ff[4];
   end

   // stage 6 inputs: foot beyond the horizontal length
   always_comb begin
      sd_in[6]         = sd_ff[5];
      sd_in[6].outside = (sqa_ff > SQA_W'(sqd_ff)) || (sqb_ff > SQA_W'(sqd_ff));
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NST; k++) begin
            sd_ff[k] <= sd_in[k];
         end
         e_ff    <= e_in;
         u_ff    <= u_in;
         v_ff    <= v_in;
         pc_ff   <= pc_in;
         pee_ff  <= pee_in;
         pu_ff   <= pu_in;
         pv_ff   <= pv_in;
         c_ff    <= c_in;
         dd2_ff  <= dd2_in;
         d22_ff  <= d22_in;
         ps_ff   <= ps_in;
         pf_ff   <= pf_in;
         apf3_ff <= apf3_in;
         aps3_ff <= aps3_in;
         dd3_ff  <= dd2_ff;
         d23_ff  <= d22_ff;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         pd_ff   <= pd_in;
         apf4_ff <= apf3_ff;
         dd4_ff  <= dd3_ff;
         sqa_ff  <= sqa_in;
         sqb_ff  <= sqb_in;
         sqd_ff  <= sqd_in;
         apf5_ff <= apf4_ff;
         dd5_ff  <= dd4_ff;
         op6_ff.apf <= apf5_ff;
         op6_ff.dd  <= dd5_ff;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_side  = sd_ff[NST-1];
   assign out_op    = op6_ff;

endmodule

>>> hdl/nspa_div.sv
// Pipelined restoring divider: one quotient bit of |pf| * 2^FRAC_BITS / dd
// per stage, saturating at one. Depends on nspa_pkg and the assertion header.
`timescale 1ns / 1ps
`include "nearest_segment_point_to_anchor_top_assert.svh"
module nspa_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  nspa_pkg::side_type   in_side,
   input  nspa_pkg::divop_type  in_op,
   output logic                 out_valid,
   input  logic                 out_ready,
   output nspa_pkg::side_type   out_side,
   output logic                 out_sat,
   output logic [FRAC_BITS-1:0] out_quo
);
   import nspa_pkg::*;

   localparam int NST = FRAC_BITS + 1;

   logic [NST-1:0]       vld_ff, vld_in;
   logic [NST-1:0]       sat_ff, sat_in;
   logic                 en;
   side_type             sd_ff [NST];
   logic [DD_W-1:0]      dd_ff [NST];
   logic [DD_W-1:0]      rem_ff [NST], rem_in [NST];
   logic [FRAC_BITS-1:0] quo_ff [NST], quo_in [NST];
   logic [DD_W:0]        r2 [NST];
   logic [NST-1:0]       ge;

   always_comb begin
      en       = !vld_ff[NST-1] || out_ready;
      in_ready = en;
      vld_in   = en ? {vld_ff[NST-2:0], in_valid} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // quotient of one or more: fraction is taken as zero downstream
   always_comb begin
      sat_in[0] = in_op.apf >= MAG_W'(in_op.dd);
      for (int k = 1; k < NST; k++) begin
         sat_in[k] = sat_ff[k-1];
      end
      rem_in[0] = sat_in[0] ? '0 : in_op.apf[DD_W-1:0];
      quo_in[0] = '0;
      r2[0]     = '0;
      ge[0]     = 1'b0;
      // one shift-compare-subtract per stage; saturated items keep a zero
      // quotient, even with an empty divisor
      for (int k = 1; k < NST; k++) begin
         r2[k]     = {rem_ff[k-1], 1'b0};
         ge[k]     = !sat_ff[k-1] && (r2[k] >= {1'b0, dd_ff[k-1]});
         rem_in[k] = ge[k] ? DD_W'(r2[k] - {1'b0, dd_ff[k-1]}) : r2[k][DD_W-1:0];
         quo_in[k] = {quo_ff[k-1][FRAC_BITS-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff   <= sat_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         sd_ff[0] <= in_side;
         dd_ff[0] <= in_op.dd;
         for (int k = 1; k < NST; k++) begin
            sd_ff[k] <= sd_ff[k-1];
            dd_ff[k] <= dd_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_side  = sd_ff[NST-1];
   assign out_sat   = sat_ff[NST-1];
   assign out_quo   = quo_ff[NST-1];

   `NSPA_ASSERT_IMP(rem_bound_a, vld_ff[NST-1] && !sat_ff[NST-1], rem_ff[NST-1] < dd_ff[NST-1], "divider remainder not below divisor")
   `NSPA_ASSERT_IMP(sat_zero_a, vld_ff[NST-1] && sat_ff[NST-1], quo_ff[NST-1] == '0, "saturated division left quotient bits")

endmodule

>>> hdl/nspa_back.sv
// Back end: fraction t, linear interpolation, truncation toward zero and the
// endpoint selection rules; the last stage is the output register.
// Depends on nspa_pkg and the assertion header.
`timescale 1ns / 1ps
`include "nearest_segment_point_to_anchor_top_assert.svh"
module nspa_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  nspa_pkg::side_type   in_side,
   input  logic                 in_sat,
   input  logic [FRAC_BITS-1:0] in_quo,
   output logic                 out_valid,
   input  logic                 out_ready,
   output nspa_pkg::res_type    out_res
);
   import nspa_pkg::*;

   localparam int NST   = 4;
   localparam int T_W   = FRAC_BITS + 1;
   localparam int PRD_W = T_W + 1 + DIFF_W;
   localparam int ACC_W = PRD_W + 1;
   localparam int R_W   = ACC_W - FRAC_BITS;
   localparam logic [T_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [ACC_W-1:0] BIAS = {{(ACC_W-FRAC_BITS){1'b0}},
                                                {FRAC_BITS{1'b1}}};

   logic [NST-1:0]          vld_ff, vld_in;
   logic                    en;
   side_type                sd_ff [NST-1];
   logic [T_W-1:0]          t0_ff, t0_in;
   logic signed [DIFF_W-1:0] e0_ff [3], e0_in [3];
   logic signed [PRD_W-1:0] prod_ff [3], prod_in [3];
   logic signed [ACC_W-1:0] acc_ff [3], acc_in [3];
   logic signed [ACC_W-1:0] biased [3];
   logic signed [R_W-1:0]   quot [3];
   coord_type               interp [3];
   coord_type               pick [3];
   res_type                 res_ff, res_in;

   function automatic coord_type seg_s(seg_type sg, int unsigned i);
      case (i)
         0:       return sg.sx;
         1:       return sg.sy;
         default: return sg.sz;
      endcase
   endfunction

   function automatic coord_type seg_f(seg_type sg, int unsigned i);
      case (i)
         0:       return sg.fx;
         1:       return sg.fy;
         default: return sg.fz;
      endcase
   endfunction

   always_comb begin
      en       = !vld_ff[NST-1] || out_ready;
      in_ready = en;
      vld_in   = en ? {vld_ff[NST-2:0], in_valid} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: t = 1 - quotient, endpoint differences
   always_comb begin
      t0_in = in_sat ? '0 : ONE - T_W'(in_quo);
      for (int i = 0; i < 3; i++) begin
         e0_in[i] = DIFF_W'(seg_f(in_side.seg, i)) - DIFF_W'(seg_s(in_side.seg, i));
      end
   end

   // stage 1: t * (f - s); stage 2: add the start point
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PRD_W'($signed({1'b0, t0_ff})) * PRD_W'(e0_ff[i]);
         acc_in[i]  = (ACC_W'(seg_s(sd_ff[1].seg, i)) <<< FRAC_BITS) + ACC_W'(prod_ff[i]);
      end
   end

   // stage 3: truncate toward zero, saturate, apply the endpoint rules
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         biased[i] = acc_ff[i][ACC_W-1] ? acc_ff[i] + BIAS : acc_ff[i];
         quot[i]   = R_W'(biased[i] >>> FRAC_BITS);
         if (quot[i][R_W-1:COORD_W-1] == '0 || quot[i][R_W-1:COORD_W-1] == '1) begin
            interp[i] = quot[i][COORD_W-1:0];
         end else begin
            interp[i] = {quot[i][R_W-1], {(COORD_W-1){!quot[i][R_W-1]}}};
         end
         if (sd_ff[2].collinear) begin
            pick[i] = sd_ff[2].near_start ? seg_s(sd_ff[2].seg, i) : seg_f(sd_ff[2].seg, i);
         end else if (sd_ff[2].outside && sd_ff[2].pf_gt) begin
            pick[i] = seg_s(sd_ff[2].seg, i);
         end else if (sd_ff[2].outside && sd_ff[2].pf_lt) begin
            pick[i] = seg_f(sd_ff[2].seg, i);
         end else begin
            pick[i] = interp[i];
         end
      end
      res_in.near_x = pick[0];
      res_in.near_y = pick[1];
      // vertical segment: lower end in z
      if (sd_ff[2].zero_horiz) begin
         res_in.near_z = (sd_ff[2].seg.sz > sd_ff[2].seg.fz) ? sd_ff[2].seg.fz
                                                            : sd_ff[2].seg.sz;
      end else begin
         res_in.near_z = pick[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= in_side;
         sd_ff[1] <= sd_ff[0];
         sd_ff[2] <= sd_ff[1];
         t0_ff    <= t0_in;
         e0_ff    <= e0_in;
         prod_ff  <= prod_in;
         acc_ff   <= acc_in;
         res_ff   <= res_in;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_res   = res_ff;

   `NSPA_ASSERT_IMP(t_bound_a, vld_ff[0], t0_ff <= ONE, "interpolation fraction above one")
   `NSPA_ASSERT_NXT(stall_hold_a, !en, vld_ff == $past(vld_ff), "valid bits moved while stalled")

endmodule

>>> hdl/nearest_segment_point_to_anchor_top.sv
// Top level of the nearest segment point block: anchor registers and the
// front, divider and back pipelines. Depends on nspa_pkg, the channel
// interfaces, nspa_front, nspa_div and nspa_back.
// Each request transfer carries a 3D segment and a winch number; the response
// is the point of the segment nearest that winch's anchor, in whole
// millimetres truncated toward zero. The pipeline takes one request per
// cycle while no stall holds it and presents the responses in order. The
// divider resolves one bit of the fraction along the segment per stage, so
// its depth grows with FRAC_BITS. A stalled response halts the back section;
// the divider, then the front, halts in turn when its last stage holds an item
// and the section after it is halted. Gaps inside a halted section are not
// closed up. Anchor registers are written through the csr port; the user must
// write them only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
module nearest_segment_point_to_anchor_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  nspa_pkg::csr_idx_type       csr_index,
   input  logic [nspa_pkg::CFG_W-1:0]  csr_wdata,
   nspa_req_if.sink                    req_chan,
   nspa_rsp_if.source                  rsp_chan
);
   import nspa_pkg::*;

   anchor_type           anchors_ff, anchors_in;
   seg_type              req_seg;
   logic                 f_valid, f_ready;
   side_type             f_side;
   divop_type            f_op;
   logic                 d_valid, d_ready;
   side_type             d_side;
   logic                 d_sat;
   logic [FRAC_BITS-1:0] d_quo;
   res_type              res;

   // anchor registers
   always_comb begin
      anchors_in = anchors_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_A_X_OFF: anchors_in.a_x_off = csr_wdata;
            REG_B_X_OFF: anchors_in.b_x_off = csr_wdata;
            REG_B_Y:     anchors_in.b_y     = csr_wdata;
            REG_C_X:     anchors_in.c_x     = csr_wdata;
            REG_C_Y:     anchors_in.c_y     = csr_wdata;
            REG_D_X:     anchors_in.d_x     = csr_wdata;
            default:     anchors_in = anchors_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchors_ff <= '0;
      end else begin
         anchors_ff <= anchors_in;
      end
   end

   always_comb begin
      req_seg.sx = req_chan.seg_start_x;
      req_seg.sy = req_chan.seg_start_y;
      req_seg.sz = req_chan.seg_start_z;
      req_seg.fx = req_chan.seg_end_x;
      req_seg.fy = req_chan.seg_end_y;
      req_seg.fz = req_chan.seg_end_z;
   end

   nspa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .anchors   (anchors_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_seg    (req_seg),
      .in_sel    (req_chan.winch_sel),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_side  (f_side),
      .out_op    (f_op)
   );

   nspa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_side   (f_side),
      .in_op     (f_op),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_side  (d_side),
      .out_sat   (d_sat),
      .out_quo   (d_quo)
   );

   nspa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_side   (d_side),
      .in_sat    (d_sat),
      .in_quo    (d_quo),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_res   (res)
   );

   assign rsp_chan.near_x = res.near_x;
   assign rsp_chan.near_y = res.near_y;
   assign rsp_chan.near_z = res.near_z;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for nearest_segment_point_to_anchor_top: directed and
// random segment queries against an in-bench predictor. Depends on nspa_pkg,
// nspa_req_if, nspa_rsp_if and the block's RTL.
`timescale 1ns / 1ps
module testbench;
   import nspa_pkg::*;

   localparam int FRAC        = 16;
   localparam int LATENCY     = FRAC + 12;
   localparam int WATCHDOG    = 20000;
   localparam int RANDOM_ITEMS = 1130;

   typedef struct packed {
      coord_type        sx, sy, sz, fx, fy, fz;
      logic [SEL_W-1:0] winch;
   } query_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   csr_idx_type csr_index;
   logic [CFG_W-1:0] csr_wdata;

   nspa_req_if req_chan ();
   nspa_rsp_if rsp_chan ();

   nearest_segment_point_to_anchor_top #(.FRAC_BITS(FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source)
   );

   // Anchor settings as the predictor sees them
   logic [CFG_W-1:0] anc_a_xo, anc_b_xo, anc_b_y, anc_c_x, anc_c_y, anc_d_x;

   query_type pending_queries[$];
   res_type   expected_points[$];
   int        mismatches;
   int        idle_cycles;
   bit        timed_out;
   bit        quiet_phase;   // no random idling on either side
   int        hold_off;      // receiver hold-off cycles still to run
   bit        drain_pause;   // sender waits for every expected point

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 128-bit square comparison: a*a > b*c
   function automatic bit sq_exceeds(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] lhs, rhs;
      lhs = {64'd0, a} * {64'd0, a};
      rhs = {64'd0, b} * {64'd0, c};
      return lhs > rhs;
   endfunction

   function automatic longint lerp_coord(longint s, longint f, longint t);
      longint acc, r;
      acc = s * (longint'(1) << FRAC) + t * (f - s);
      r = acc / (longint'(1) << FRAC);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   // Nearest point on the segment to the selected winch anchor
   function automatic res_type nearest_point(query_type q);
      res_type r;
      longint sx, sy, sz, fx, fy, fz, ax, ay;
      longint ex, ey, ez, ux, uy, uz, cx, cy, cz, dd, d2, ps, pf, t, one;
      longint rx, ry, rz;
      logic [63:0] apf, aps, quo;
      int w;
      bit near_start;
      sx = q.sx; sy = q.sy; sz = q.sz; fx = q.fx; fy = q.fy; fz = q.fz;
      w = (q.winch > 3) ? 3 : int'(q.winch);
      case (w)
         0: begin ax = -longint'(anc_a_xo); ay = 0; end
         1: begin ax = -longint'(anc_b_xo); ay = anc_b_y; end
         2: begin ax = anc_c_x; ay = anc_c_y; end
         default: begin ax = anc_d_x; ay = 0; end
      endcase
      ex = fx - sx; ey = fy - sy; ez = fz - sz;
      ux = ax - sx; uy = ay - sy; uz = -sz;
      cx = ey * uz - ez * uy;
      cy = ez * ux - ex * uz;
      cz = ex * uy - ey * ux;
      dd = ex * ex + ey * ey + ez * ez;
      d2 = ex * ex + ey * ey;
      ps = ux * ex + uy * ey + uz * ez;
      pf = (ax - fx) * (-ex) + (ay - fy) * (-ey) + (-fz) * (-ez);
      if (cx == 0 && cy == 0 && cz == 0) begin
         // collinear or degenerate: endpoint by side of the winch
         near_start = (sx <= fx) ? (w <= 1) : (w >= 2);
         rx = near_start ? sx : fx;
         ry = near_start ? sy : fy;
         rz = near_start ? sz : fz;
      end else begin
         apf = (pf < 0) ? -pf : pf;
         aps = (ps < 0) ? -ps : ps;
         one = longint'(1) << FRAC;
         quo = (apf << FRAC) / dd;
         t = (quo >= one) ? 0 : one - longint'(quo);
         rx = lerp_coord(sx, fx, t);
         ry = lerp_coord(sy, fy, t);
         rz = lerp_coord(sz, fz, t);
         // foot beyond an end of the segment
         if (sq_exceeds(apf, dd, d2) || sq_exceeds(aps, dd, d2)) begin
            if (apf > aps) begin
               rx = sx; ry = sy; rz = sz;
            end else if (apf < aps) begin
               rx = fx; ry = fy; rz = fz;
            end
         end
      end
      if (d2 == 0) rz = (sz > fz) ? fz : sz;
      r.near_x = coord_type'(rx);
      r.near_y = coord_type'(ry);
      r.near_z = coord_type'(rz);
      return r;
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return coord_type'($urandom_range(0, 20) - 10);
         3, 4: return coord_type'($urandom);
         default: return coord_type'(int'($urandom_range(0, 8000)) - 4000);
      endcase
   endfunction

   task automatic add_query(coord_type sx, sy, sz, fx, fy, fz, logic [SEL_W-1:0] w);
      query_type q;
      q = '{sx, sy, sz, fx, fy, fz, w};
      pending_queries.push_back(q);
   endtask

   task automatic add_random_query();
      coord_type sx, sy, sz, fx, fy, fz;
      logic [SEL_W-1:0] w;
      sx = pick_coord(); sy = pick_coord(); sz = pick_coord();
      w = SEL_W'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0: begin fx = sx; fy = sy; fz = pick_coord(); end   // vertical
         1: begin fx = sx; fy = sy; fz = sz; end             // point segment
         2: begin fx = coord_type'(sx + 3); fy = coord_type'(sy + 7); fz = sz; end  // short
         default: begin fx = pick_coord(); fy = pick_coord(); fz = pick_coord(); end
      endcase
      add_query(sx, sy, sz, fx, fy, fz, w);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_A_X_OFF: anc_a_xo = val;
         REG_B_X_OFF: anc_b_xo = val;
         REG_B_Y:     anc_b_y  = val;
         REG_C_X:     anc_c_x  = val;
         REG_C_Y:     anc_c_y  = val;
         default:     anc_d_x  = val;
      endcase
   endtask

   task automatic write_anchors(logic [CFG_W-1:0] a, b, c, d, e, f);
      write_reg(REG_A_X_OFF, a);
      write_reg(REG_B_X_OFF, b);
      write_reg(REG_B_Y, c);
      write_reg(REG_C_X, d);
      write_reg(REG_C_Y, e);
      write_reg(REG_D_X, f);
   endtask

   task automatic wait_idle();
      while (pending_queries.size() != 0 || expected_points.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: the head of the queue is the item on offer
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_points.push_back(nearest_point(pending_queries.pop_front()));
         end
         if ((req_chan.valid && !req_chan.ready) ||
             (pending_queries.size() != 0 &&
              !drain_pause && (quiet_phase || $urandom_range(0, 99) >= 11))) begin
            req_chan.valid <= 1'b1;
            req_chan.seg_start_x <= pending_queries[0].sx;
            req_chan.seg_start_y <= pending_queries[0].sy;
            req_chan.seg_start_z <= pending_queries[0].sz;
            req_chan.seg_end_x   <= pending_queries[0].fx;
            req_chan.seg_end_y   <= pending_queries[0].fy;
            req_chan.seg_end_z   <= pending_queries[0].fz;
            req_chan.winch_sel   <= pending_queries[0].winch;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_off <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transfer %0d %0d %0d",
                     rsp_chan.near_x, rsp_chan.near_y, rsp_chan.near_z);
            end else begin
               res_type e;
               e = expected_points.pop_front();
               if (e.near_x !== rsp_chan.near_x || e.near_y !== rsp_chan.near_y ||
                   e.near_z !== rsp_chan.near_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("point mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        e.near_x, e.near_y, e.near_z,
                        rsp_chan.near_x, rsp_chan.near_y, rsp_chan.near_z);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet_phase || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // Watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus and phases
   initial begin
      mismatches = 0;
      quiet_phase = 0;
      drain_pause = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_A_X_OFF;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.seg_start_x = '0; req_chan.seg_start_y = '0; req_chan.seg_start_z = '0;
      req_chan.seg_end_x = '0; req_chan.seg_end_y = '0; req_chan.seg_end_z = '0;
      req_chan.winch_sel = '0;
      rsp_chan.ready = 1'b0;
      anc_a_xo = 0; anc_b_xo = 0; anc_b_y = 0; anc_c_x = 0; anc_c_y = 0; anc_d_x = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every winch, collinear, vertical, outside the segment
      write_anchors(15'd1000, 15'd1000, 15'd2000, 15'd3000, 15'd2000, 15'd3000);
      for (int w = 0; w < 8; w++) add_query(-100, 50, 10, 200, 80, -30, SEL_W'(w));
      add_query(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
      add_query(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 3);
      add_query(-1000, 0, 0, 500, 0, 0, 0);     // collinear with winch A
      add_query(500, 0, 0, -1000, 0, 0, 2);     // reversed along x, winch C off the line
      add_query(10, 10, 10, 10, 10, 10, 1);     // point segment
      add_query(100, 200, 500, 100, 200, -300, 2); // vertical
      add_query(5000, 100, 0, 6000, 200, 0, 0); // foot beyond the start
      add_query(-6000, 100, 0, -5000, 200, 0, 3); // foot beyond the finish
      add_query(-1, -1, -1, 1, 1, 1, 1);
      add_query(0, 0, 0, 0, 0, 0, 7);
      wait_idle();

      // Random phases over several anchor settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_anchors(0, 0, 0, 0, 0, 0);
            1: write_anchors(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
            2: write_anchors(15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA, 15'h5555, 15'h2AAA);
            default: write_anchors(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                   CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
         endcase
         quiet_phase = (ph == 3);
         for (int i = 0; i < RANDOM_ITEMS / 6; i++) add_random_query();
         if (ph == 1) begin
            // long receiver hold-off while requests keep coming
            @(posedge clock);
            hold_off <= 300;
         end
         if (ph == 4) begin
            // sender pauses until the pipeline has drained
            while (pending_queries.size() > 90) @(posedge clock);
            drain_pause = 1;
            while (expected_points.size() != 0 || req_chan.valid) @(posedge clock);
            drain_pause = 0;
         end
         wait_idle();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && expected_points.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
